FILE: src/acpd_pkg.sv
// Package for the autocorrelation pitch detector.
// Holds field widths, register indexes and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package acpd_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SR_W        = 18;
   localparam int FREQ_W      = 15;
   localparam int LAG_W       = 18;
   localparam int PITCH_W     = 22;
   localparam int BEST_LAG_W  = 12;
   localparam int SCORE_W     = 16;
   localparam int Q15_SHIFT   = 15;
   localparam int PITCH_SHIFT = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 18;

   localparam logic [SR_W-1:0]   SAMPLE_RATE_RESET = SR_W'(44100);
   localparam logic [FREQ_W-1:0] MIN_FREQ_RESET    = FREQ_W'(60);
   localparam logic [FREQ_W-1:0] MAX_FREQ_RESET    = FREQ_W'(500);

   localparam logic signed [SCORE_W-1:0] SCORE_MIN = {1'b1, {(SCORE_W-1){1'b0}}};
   localparam logic signed [SCORE_W-1:0] SCORE_MAX = {1'b0, {(SCORE_W-1){1'b1}}};

   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_RATE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_FREQ    = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FREQ    = CSR_IDX_W'(2);

   typedef enum logic [1:0] {
      DIV_MIN_LAG,
      DIV_MAX_LAG,
      DIV_SCORE,
      DIV_PITCH
   } div_sel_type;

   typedef struct packed {
      logic        wr_sample;
      logic        div_start;
      div_sel_type div_sel;
      logic        cap_min;
      logic        cap_max;
      logic        lag_init;
      logic        mac_start;
      logic        mul_start;
      logic        sqrt_start;
      logic        score_upd;
      logic        lag_inc;
      logic        rsp_load;
   } acpd_cmd_type;

   typedef struct packed {
      logic div_done;
      logic mac_done;
      logic mul_done;
      logic sqrt_done;
      logic lag_over;
      logic energy_zero;
      logic root_zero;
      logic pitch_div;
   } acpd_status_type;

endpackage

`default_nettype wire

FILE: src/acpd_datapath.sv
// Datapath of the pitch detector: config registers, frame store, MAC pipeline,
// shift-add multiplier, digit square root, restoring divider and result registers.
// Depends on acpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acpd_datapath
   import acpd_pkg::*;
#(
   parameter int FRAME_LEN = 4096
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]        csr_index,
   input  wire logic [CSR_DATA_W-1:0]       csr_wdata,
   input  wire logic signed [SAMPLE_W-1:0]  req_sample,
   input  wire acpd_cmd_type                cmd,
   output acpd_status_type                  status,
   output logic [PITCH_W-1:0]               rsp_pitch_x16,
   output logic [BEST_LAG_W-1:0]            rsp_best_lag,
   output logic                             rsp_pitch_found,
   output logic                             rsp_frame_truncated
);

   localparam int AW  = $clog2(FRAME_LEN);
   localparam int CW  = $clog2(FRAME_LEN + 1);
   localparam int EW  = 2 * SAMPLE_W - 1 + AW;
   localparam int DW  = 2 * SAMPLE_W + AW;
   localparam int PW  = 2 * EW;
   localparam int NW  = DW + Q15_SHIFT;
   localparam int RW  = EW + 2;
   localparam int LCW = LAG_W + 1;
   localparam int MCW = $clog2(EW + 1);
   localparam int DCW = $clog2(NW + 1);

   // Configuration registers.
   logic [SR_W-1:0]   sample_rate_ff;
   logic [FREQ_W-1:0] min_freq_ff;
   logic [FREQ_W-1:0] max_freq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_rate_ff <= SAMPLE_RATE_RESET;
         min_freq_ff    <= MIN_FREQ_RESET;
         max_freq_ff    <= MAX_FREQ_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_SAMPLE_RATE: sample_rate_ff <= csr_wdata[SR_W-1:0];
            CSR_MIN_FREQ:    min_freq_ff    <= csr_wdata[FREQ_W-1:0];
            CSR_MAX_FREQ:    max_freq_ff    <= csr_wdata[FREQ_W-1:0];
            default: ;
         endcase
      end
   end

   // Frame store and fill count.
   logic signed [SAMPLE_W-1:0] frame_mem [FRAME_LEN];
   logic [CW-1:0]              count_ff;
   logic                       overflow_ff;
   logic                       count_full;
   logic [CW-1:0]              i_ff;
   logic [LAG_W-1:0]           lag_ff;
   logic [LCW-1:0]             pair_idx;
   logic                       issue_ok;
   logic [AW-1:0]              addr_a;
   logic [AW-1:0]              addr_b;
   logic signed [SAMPLE_W-1:0] rd_a_ff;
   logic signed [SAMPLE_W-1:0] rd_b_ff;

   assign count_full = (count_ff == CW'(FRAME_LEN));
   assign pair_idx   = {1'b0, lag_ff} + LCW'(i_ff);
   assign issue_ok   = (pair_idx < LCW'(count_ff));
   assign addr_a     = i_ff[AW-1:0];
   assign addr_b     = pair_idx[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_sample && !count_full) begin
         frame_mem[count_ff[AW-1:0]] <= req_sample;
      end
      rd_a_ff <= frame_mem[addr_a];
      rd_b_ff <= frame_mem[addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         count_ff    <= '0;
         overflow_ff <= 1'b0;
      end else if (cmd.wr_sample) begin
         if (count_full) begin
            overflow_ff <= 1'b1;
         end else begin
            count_ff <= count_ff + CW'(1);
         end
      end
   end

   // MAC pipeline: issue addresses, read, multiply, accumulate.
   logic                         mac_run_ff;
   logic                         mac_act_ff;
   logic                         v1_ff;
   logic                         v2_ff;
   logic                         mac_done;
   logic signed [2*SAMPLE_W-1:0] p_ab_ff;
   logic signed [2*SAMPLE_W-1:0] p_aa_ff;
   logic signed [2*SAMPLE_W-1:0] p_bb_ff;
   logic signed [DW-1:0]         dot_ff;
   logic [EW-1:0]                e1_ff;
   logic [EW-1:0]                e2_ff;

   assign mac_done = mac_act_ff && !mac_run_ff && !v1_ff && !v2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_run_ff <= 1'b0;
         mac_act_ff <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
      end else begin
         v1_ff <= mac_run_ff && issue_ok;
         v2_ff <= v1_ff;
         if (cmd.mac_start) begin
            mac_run_ff <= 1'b1;
            mac_act_ff <= 1'b1;
         end else begin
            if (mac_run_ff && !issue_ok) begin
               mac_run_ff <= 1'b0;
            end
            if (mac_done) begin
               mac_act_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ab_ff <= rd_a_ff * rd_b_ff;
      p_aa_ff <= rd_a_ff * rd_a_ff;
      p_bb_ff <= rd_b_ff * rd_b_ff;
      if (cmd.mac_start) begin
         i_ff   <= '0;
         dot_ff <= '0;
         e1_ff  <= '0;
         e2_ff  <= '0;
      end else begin
         if (mac_run_ff && issue_ok) begin
            i_ff <= i_ff + CW'(1);
         end
         if (v2_ff) begin
            dot_ff <= dot_ff + DW'(p_ab_ff);
            e1_ff  <= e1_ff + EW'(p_aa_ff[2*SAMPLE_W-2:0]);
            e2_ff  <= e2_ff + EW'(p_bb_ff[2*SAMPLE_W-2:0]);
         end
      end
   end

   // Shift-add multiplier for e1 * e2, one bit of e2 per cycle.
   logic [PW-1:0]  mpa_ff;
   logic [EW-1:0]  mpb_ff;
   logic [PW-1:0]  mprod_ff;
   logic [MCW-1:0] mcnt_ff;
   logic           mul_act_ff;
   logic           mul_done;

   assign mul_done = mul_act_ff && (mcnt_ff == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_act_ff <= 1'b0;
      end else if (cmd.mul_start) begin
         mul_act_ff <= 1'b1;
      end else if (mul_done) begin
         mul_act_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_start) begin
         mpa_ff   <= PW'(e1_ff);
         mpb_ff   <= e2_ff;
         mprod_ff <= '0;
         mcnt_ff  <= MCW'(EW);
      end else if (mul_act_ff && (mcnt_ff != '0)) begin
         if (mpb_ff[0]) begin
            mprod_ff <= mprod_ff + mpa_ff;
         end
         mpa_ff  <= mpa_ff << 1;
         mpb_ff  <= mpb_ff >> 1;
         mcnt_ff <= mcnt_ff - MCW'(1);
      end
   end

   // Digit-by-digit square root, one root bit per cycle.
   logic [PW-1:0]  rad_ff;
   logic [RW-1:0]  srem_ff;
   logic [EW-1:0]  root_ff;
   logic [MCW-1:0] scnt_ff;
   logic           sqrt_act_ff;
   logic           sqrt_done;
   logic [RW+1:0]  srem_t;
   logic [RW+1:0]  strial;
   logic [RW+1:0]  sdiff;
   logic           sge;

   assign sqrt_done = sqrt_act_ff && (scnt_ff == '0);
   assign srem_t    = {srem_ff, rad_ff[PW-1 -: 2]};
   assign strial    = (RW+2)'({root_ff, 2'b01});
   assign sge       = (srem_t >= strial);
   assign sdiff     = srem_t - strial;

   always_ff @(posedge clock) begin
      if (reset) begin
         sqrt_act_ff <= 1'b0;
      end else if (cmd.sqrt_start) begin
         sqrt_act_ff <= 1'b1;
      end else if (sqrt_done) begin
         sqrt_act_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sqrt_start) begin
         rad_ff  <= mprod_ff;
         srem_ff <= '0;
         root_ff <= '0;
         scnt_ff <= MCW'(EW);
      end else if (sqrt_act_ff && (scnt_ff != '0)) begin
         srem_ff <= sge ? sdiff[RW-1:0] : srem_t[RW-1:0];
         root_ff <= {root_ff[EW-2:0], sge};
         rad_ff  <= rad_ff << 2;
         scnt_ff <= scnt_ff - MCW'(1);
      end
   end

   // Restoring divider shared by the lag bounds, the scores and the pitch.
   logic [NW-1:0]      dvd_ff;
   logic [EW-1:0]      dvr_ff;
   logic [EW:0]        drem_ff;
   logic [DCW-1:0]     dcnt_ff;
   logic               div_act_ff;
   logic               div_done;
   logic [EW+1:0]      dr_t;
   logic [EW+1:0]      dsub;
   logic               dge;
   logic [NW-1:0]      div_num;
   logic [EW-1:0]      div_den;
   logic [FREQ_W-1:0]  fmin_eff;
   logic [FREQ_W-1:0]  fmax_eff;
   logic               dot_neg;
   logic [DW-1:0]      dot_mag;
   logic [LAG_W-1:0]   best_lag_ff;

   assign div_done = div_act_ff && (dcnt_ff == '0);
   assign dr_t     = {drem_ff, dvd_ff[NW-1]};
   assign dge      = (dr_t >= (EW+2)'(dvr_ff));
   assign dsub     = dr_t - (EW+2)'(dvr_ff);
   assign fmin_eff = (min_freq_ff == '0) ? FREQ_W'(1) : min_freq_ff;
   assign fmax_eff = (max_freq_ff == '0) ? FREQ_W'(1) : max_freq_ff;
   assign dot_neg  = dot_ff[DW-1];
   assign dot_mag  = dot_neg ? DW'(-dot_ff) : DW'(dot_ff);

   always_comb begin
      case (cmd.div_sel)
         DIV_MIN_LAG: begin
            div_num = NW'(sample_rate_ff);
            div_den = EW'(fmax_eff);
         end
         DIV_MAX_LAG: begin
            div_num = NW'(sample_rate_ff);
            div_den = EW'(fmin_eff);
         end
         DIV_SCORE: begin
            div_num = {dot_mag, {Q15_SHIFT{1'b0}}};
            div_den = root_ff;
         end
         DIV_PITCH: begin
            div_num = NW'({sample_rate_ff, {PITCH_SHIFT{1'b0}}});
            div_den = EW'(best_lag_ff);
         end
         default: begin
            div_num = '0;
            div_den = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_act_ff <= 1'b0;
      end else if (cmd.div_start) begin
         div_act_ff <= 1'b1;
      end else if (div_done) begin
         div_act_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_start) begin
         dvd_ff  <= div_num;
         dvr_ff  <= div_den;
         drem_ff <= '0;
         dcnt_ff <= DCW'(NW);
      end else if (div_act_ff && (dcnt_ff != '0)) begin
         drem_ff <= dge ? dsub[EW:0] : dr_t[EW:0];
         dvd_ff  <= {dvd_ff[NW-2:0], dge};
         dcnt_ff <= dcnt_ff - DCW'(1);
      end
   end

   // Lag range, lag walk and running best.
   logic [LAG_W-1:0]          min_lag_ff;
   logic [LAG_W-1:0]          max_lag_ff;
   logic signed [SCORE_W-1:0] best_ff;
   logic                      found_ff;
   logic signed [SCORE_W-1:0] score;

   always_comb begin
      if (dot_neg) begin
         score = (dvd_ff > NW'(32768)) ? SCORE_MIN : SCORE_W'(-dvd_ff[SCORE_W-1:0]);
      end else begin
         score = (dvd_ff > NW'(32767)) ? SCORE_MAX : dvd_ff[SCORE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else if (cmd.lag_init) begin
         found_ff <= 1'b0;
      end else if (cmd.score_upd && (score > best_ff)) begin
         found_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cap_min) begin
         min_lag_ff <= dvd_ff[LAG_W-1:0];
      end
      if (cmd.cap_max) begin
         max_lag_ff <= (dvd_ff > NW'(FRAME_LEN - 1)) ? LAG_W'(FRAME_LEN - 1)
                                                     : dvd_ff[LAG_W-1:0];
      end
      if (cmd.lag_init) begin
         lag_ff      <= min_lag_ff;
         best_ff     <= SCORE_MIN;
         best_lag_ff <= '0;
      end else begin
         if (cmd.lag_inc) begin
            lag_ff <= lag_ff + LAG_W'(1);
         end
         if (cmd.score_upd && (score > best_ff)) begin
            best_ff     <= score;
            best_lag_ff <= lag_ff;
         end
      end
   end

   // Result registers.
   logic pitch_div;

   assign pitch_div = found_ff && (best_lag_ff != '0);

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_pitch_x16       <= pitch_div ? dvd_ff[PITCH_W-1:0] : '0;
         rsp_best_lag        <= found_ff ? best_lag_ff[BEST_LAG_W-1:0] : '0;
         rsp_pitch_found     <= found_ff;
         rsp_frame_truncated <= overflow_ff;
      end
   end

   always_comb begin
      status.div_done    = div_done;
      status.mac_done    = mac_done;
      status.mul_done    = mul_done;
      status.sqrt_done   = sqrt_done;
      status.lag_over    = (lag_ff > max_lag_ff);
      status.energy_zero = (e1_ff == '0) || (e2_ff == '0);
      status.root_zero   = (root_ff == '0);
      status.pitch_div   = pitch_div;
   end

endmodule

`default_nettype wire

FILE: src/acpd_ctrl.sv
// Controller of the pitch detector: sequences frame load, lag search and result.
// Depends on acpd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module acpd_ctrl
   import acpd_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire logic            req_last_sample,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   input  wire acpd_status_type status,
   output acpd_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV_MIN,
      ST_DIV_MAX,
      ST_LAG_INIT,
      ST_CHECK,
      ST_MAC,
      ST_MUL,
      ST_SQRT,
      ST_DIV_SCORE,
      ST_NEXT,
      ST_PITCH,
      ST_DIV_PITCH,
      ST_OUT
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.div_sel = DIV_MIN_LAG;
      case (state_ff)
         ST_IDLE: begin
            cmd.wr_sample = accept;
            if (accept && req_last_sample) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_MIN;
            end
         end
         ST_DIV_MIN: begin
            if (status.div_done) begin
               cmd.cap_min   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_MAX_LAG;
               state_in      = ST_DIV_MAX;
            end
         end
         ST_DIV_MAX: begin
            if (status.div_done) begin
               cmd.cap_max = 1'b1;
               state_in    = ST_LAG_INIT;
            end
         end
         ST_LAG_INIT: begin
            cmd.lag_init = 1'b1;
            state_in     = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.lag_over) begin
               state_in = ST_PITCH;
            end else begin
               cmd.mac_start = 1'b1;
               state_in      = ST_MAC;
            end
         end
         ST_MAC: begin
            if (status.mac_done) begin
               if (status.energy_zero) begin
                  state_in = ST_NEXT;
               end else begin
                  cmd.mul_start = 1'b1;
                  state_in      = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (status.mul_done) begin
               cmd.sqrt_start = 1'b1;
               state_in       = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (status.sqrt_done) begin
               if (status.root_zero) begin
                  state_in = ST_NEXT;
               end else begin
                  cmd.div_start = 1'b1;
                  cmd.div_sel   = DIV_SCORE;
                  state_in      = ST_DIV_SCORE;
               end
            end
         end
         ST_DIV_SCORE: begin
            cmd.div_sel = DIV_SCORE;
            if (status.div_done) begin
               cmd.score_upd = 1'b1;
               state_in      = ST_NEXT;
            end
         end
         ST_NEXT: begin
            cmd.lag_inc = 1'b1;
            state_in    = ST_CHECK;
         end
         ST_PITCH: begin
            if (status.pitch_div) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_PITCH;
               state_in      = ST_DIV_PITCH;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_DIV_PITCH: begin
            if (status.div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

FILE: src/autocorrelation_pitch_detector_top.sv
// Top level of the autocorrelation pitch detector.
// Instantiates acpd_ctrl and acpd_datapath; depends on acpd_pkg.
//
// Usage: samples of one frame arrive as transactions on the req_ channel
// (valid/ready). Each accepted sample is written to the frame store; once the
// store holds FRAME_LEN samples, further samples are dropped and the result's
// frame_truncated bit is set. The transaction with req_last_sample high closes
// the frame and starts the lag search; req_ready stays low until the result
// has been placed in the output register.
// Samples are accepted back to back while idle. The search first runs two
// divisions for the lag bounds, then for each lag a multiply-accumulate over
// the overlap (two frame-store read ports, one pair per cycle) plus the
// product, the square root and the Q15 division, each one bit per cycle, and
// the lag step (EW = 31 + log2(FRAME_LEN) is the width of the energies and the
// root, NW = 47 + log2(FRAME_LEN) that of the quotient); a lag without energy
// skips the product, the square root and the division. A last division gives
// the pitch. The result is one transaction on the rsp_ channel. If the
// receiver stalls, the result holds in the output register; samples of the
// next frame are still accepted meanwhile, but a new search cannot finish
// until the slot frees. Reset (synchronous, active high) empties the frame,
// clears all handshakes and restores the registers to 44100 Hz, 60 Hz and
// 500 Hz. The configuration port writes one register per cycle with csr_wr_en;
// the user must use it only while idle, as the block does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module autocorrelation_pitch_detector_top
   import acpd_pkg::*;
#(
   parameter int FRAME_LEN = 4096
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]       csr_index,
   input  wire logic [CSR_DATA_W-1:0]      csr_wdata,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic signed [SAMPLE_W-1:0] req_sample,
   input  wire logic                       req_last_sample,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [PITCH_W-1:0]              rsp_pitch_x16,
   output logic [BEST_LAG_W-1:0]           rsp_best_lag,
   output logic                            rsp_pitch_found,
   output logic                            rsp_frame_truncated
);

   // The controller only issues commands and reads status; all arithmetic,
   // storage and the result registers live in the datapath.
   acpd_cmd_type    cmd;
   acpd_status_type status;

   acpd_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_last_sample (req_last_sample),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .status          (status),
      .cmd             (cmd)
   );

   acpd_datapath #(
      .FRAME_LEN (FRAME_LEN)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_wr_en           (csr_wr_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_sample          (req_sample),
      .cmd                 (cmd),
      .status              (status),
      .rsp_pitch_x16       (rsp_pitch_x16),
      .rsp_best_lag        (rsp_best_lag),
      .rsp_pitch_found     (rsp_pitch_found),
      .rsp_frame_truncated (rsp_frame_truncated)
   );

endmodule

`default_nettype wire

FILE: src/acpd_checker.sv
// Port-level checker for the pitch detector, bound to the top level.
// Depends on acpd_pkg and autocorrelation_pitch_detector_top.
`timescale 1ns / 1ps
`default_nettype none

module acpd_checker
   import acpd_pkg::*;
(
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_ready,
   input wire logic                       req_last_sample,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_ready,
   input wire logic [PITCH_W-1:0]         rsp_pitch_x16,
   input wire logic [BEST_LAG_W-1:0]      rsp_best_lag,
   input wire logic                       rsp_pitch_found
);

   // A stalled result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pitch_x16)
                                  && $stable(rsp_best_lag))
      else $error("result changed while stalled");

   // Without a winning lag the lag and pitch read zero.
   a_no_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pitch_found |-> rsp_best_lag == '0 && rsp_pitch_x16 == '0)
      else $error("nonzero result without a pitch");

   // A winning lag of zero yields no pitch.
   a_lag_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_best_lag == '0 |-> rsp_pitch_x16 == '0)
      else $error("pitch reported for lag zero");

   // Closing a frame stops sample intake for the search.
   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_last_sample |=> !req_ready)
      else $error("sample accepted right after frame end");

endmodule

bind autocorrelation_pitch_detector_top acpd_checker u_acpd_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_last_sample (req_last_sample),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_pitch_x16   (rsp_pitch_x16),
   .rsp_best_lag    (rsp_best_lag),
   .rsp_pitch_found (rsp_pitch_found)
);

`default_nettype wire
